// ----- design/sps_pkg.sv -----
// shared types, constants and conversion functions of the servo ping-pong sequencer
// no dependencies
`timescale 1ns / 1ps

package sps_pkg;

  localparam int CfgWidth   = 16;
  localparam int CfgIdxW    = 3;
  localparam int TimeW      = 32;
  localparam int RawStepsW  = 16;
  localparam int AngleW     = 9;
  localparam int StepsW     = 11;

  localparam logic [AngleW-1:0]   MaxAngle     = AngleW'(270);
  localparam logic [15:0]         SwapLimit    = 16'd360;
  localparam logic [StepsW-1:0]   MaxSteps     = StepsW'(1024);
  localparam logic [15:0]         DefaultSpeed = 16'd1500;
  localparam logic [15:0]         DefaultDwell = 16'd300;
  localparam logic [AngleW-1:0]   ArriveTol    = AngleW'(3);

  // floor(x / 270) == (x * StepsRecip) >> StepsShift for every x below 2^19
  localparam int                  StepsShift   = 28;
  localparam logic [19:0]         StepsRecip   = 20'd994206;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOOP_ENABLE = 3'd0,
    CFG_ANGLE_A     = 3'd1,
    CFG_ANGLE_B     = 3'd2,
    CFG_DWELL_MS    = 3'd3,
    CFG_LOOP_SPEED  = 3'd4,
    CFG_LOOP_TIME   = 3'd5,
    CFG_GOAL_SPEED  = 3'd6,
    CFG_GOAL_TIME   = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_MOVING = 2'd1,
    PH_DWELL  = 2'd2
  } phase_t;

  typedef struct packed {
    logic        loop_enable;
    logic [15:0] angle_a;
    logic [15:0] angle_b;
    logic [15:0] dwell_ms;
    logic [15:0] loop_speed;
    logic [15:0] loop_time;
    logic [15:0] goal_speed;
    logic [15:0] goal_time;
  } sps_cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic               toward_b;
    logic [AngleW-1:0]  target_angle;
    logic [TimeW-1:0]   dwell_start;
    logic [AngleW-1:0]  last_angle;
  } sps_state_t;

  typedef struct packed {
    logic                 mode;
    logic [TimeW-1:0]     now_ms;
    logic                 position_valid;
    logic [RawStepsW-1:0] present_steps;
  } sps_item_t;

  typedef struct packed {
    logic               move_valid;
    logic [StepsW-1:0]  move_steps;
    logic [15:0]        move_speed;
    logic [15:0]        move_time;
    logic [AngleW-1:0]  present_angle;
    logic [1:0]         loop_phase;
  } sps_result_t;

  // raw endpoint angle: undo byte swap, clamp to full travel
  function automatic logic [AngleW-1:0] raw_to_angle(input logic [15:0] raw);
    logic [15:0] deg;
    deg = (raw > SwapLimit) ? {raw[7:0], raw[15:8]} : raw;
    if (deg > 16'(MaxAngle)) begin
      deg = 16'(MaxAngle);
    end
    return deg[AngleW-1:0];
  endfunction

  // round(deg * 1024 / 270) by reciprocal multiply
  function automatic logic [StepsW-1:0] angle_to_steps(input logic [AngleW-1:0] deg);
    logic [18:0] num;
    logic [38:0] prod;
    logic [StepsW-1:0] q;
    num  = {deg, 10'b0} + 19'd135;
    prod = 39'(num) * 39'(StepsRecip);
    q    = prod[38:StepsShift];
    return (q > MaxSteps) ? MaxSteps : q;
  endfunction

  // round(steps * 270 / 1024), clamped
  function automatic logic [AngleW-1:0] steps_to_angle(input logic [RawStepsW-1:0] s);
    logic [24:0] p;
    logic [14:0] deg;
    p   = 25'(s) * 25'(MaxAngle) + 25'd512;
    deg = p[24:10];
    return (deg > 15'(MaxAngle)) ? MaxAngle : deg[AngleW-1:0];
  endfunction

endpackage

// ----- design/sps_step.sv -----
// next-state and result logic of the ping-pong loop for one transaction
// depends on sps_pkg
`timescale 1ns / 1ps

module sps_step import sps_pkg::*; (
  input  sps_cfg_t    cfg,
  input  sps_state_t  st,
  input  sps_item_t   item,
  output sps_state_t  st_nxt,
  output sps_result_t res
);

  logic              mv_req;
  logic              mv_use_b;
  logic [15:0]       mv_raw;
  logic [AngleW-1:0] mv_deg;
  logic [15:0]       spd;
  logic [15:0]       tim;
  logic [15:0]       dwell;
  logic [AngleW-1:0] new_last;
  logic [AngleW-1:0] diff;
  logic [TimeW-1:0]  elapsed;

  always_comb begin
    new_last = item.position_valid ? steps_to_angle(item.present_steps) : st.last_angle;
    diff     = (new_last > st.target_angle) ? new_last - st.target_angle
                                            : st.target_angle - new_last;
    dwell    = (cfg.dwell_ms == 16'd0) ? DefaultDwell : cfg.dwell_ms;
    elapsed  = item.now_ms - st.dwell_start;

    st_nxt   = st;
    mv_req   = 1'b0;
    mv_use_b = 1'b0;

    if (item.mode) begin
      if (cfg.loop_enable) begin
        st_nxt.phase    = PH_MOVING;
        st_nxt.toward_b = 1'b1;
        mv_req          = 1'b1;
      end else begin
        st_nxt.phase = PH_IDLE;
      end
    end else begin
      st_nxt.last_angle = new_last;
      if (cfg.loop_enable) begin
        case (st.phase)
          PH_IDLE: begin
            st_nxt.phase    = PH_MOVING;
            st_nxt.toward_b = 1'b1;
            mv_req          = 1'b1;
          end
          PH_MOVING: begin
            if (diff <= ArriveTol) begin
              st_nxt.phase       = PH_DWELL;
              st_nxt.dwell_start = item.now_ms;
            end
          end
          PH_DWELL: begin
            if (elapsed >= TimeW'(dwell)) begin
              st_nxt.phase    = PH_MOVING;
              st_nxt.toward_b = ~st.toward_b;
              mv_req          = 1'b1;
              mv_use_b        = st.toward_b;
            end
          end
          default: begin
            // unreachable phase code holds
          end
        endcase
      end else begin
        st_nxt.phase = PH_IDLE;
      end
    end

    mv_raw = mv_use_b ? cfg.angle_b : cfg.angle_a;
    mv_deg = raw_to_angle(mv_raw);
    spd    = (cfg.loop_speed != 16'd0) ? cfg.loop_speed : cfg.goal_speed;
    tim    = (cfg.loop_time != 16'd0) ? cfg.loop_time : cfg.goal_time;
    if (spd == 16'd0 && tim == 16'd0) begin
      spd = DefaultSpeed;
    end

    if (mv_req) begin
      st_nxt.target_angle = mv_deg;
    end

    res.move_valid    = mv_req;
    res.move_steps    = mv_req ? angle_to_steps(mv_deg) : '0;
    res.move_speed    = mv_req ? spd : '0;
    res.move_time     = mv_req ? tim : '0;
    res.present_angle = st_nxt.last_angle;
    res.loop_phase    = st_nxt.phase;
  end

endmodule

// ----- design/servo_ping_pong_sequencer.sv -----
// servo ping-pong sequencer: moves a servo between two endpoints with dwell
// an input transaction passes through the input register and then the result register
// throughput one transaction per cycle while the result is not stalled; loop state updates as the result register loads
// synchronous active-low reset clears valids, loop state and all config registers
// depends on sps_pkg and sps_step
`timescale 1ns / 1ps

module servo_ping_pong_sequencer import sps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgWidth-1:0]  cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode,
  input  logic [TimeW-1:0]     in_now_ms,
  input  logic                 in_position_valid,
  input  logic [RawStepsW-1:0] in_present_steps,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_move_valid,
  output logic [StepsW-1:0]    out_move_steps,
  output logic [15:0]          out_move_speed,
  output logic [15:0]          out_move_time,
  output logic [AngleW-1:0]    out_present_angle,
  output logic [1:0]           out_loop_phase
);

  sps_cfg_t    cfg_r;
  sps_state_t  st_r, st_nxt;
  sps_item_t   item_r;
  logic        item_valid_r;
  sps_result_t res_r, res_nxt;
  logic        out_valid_r;
  logic        advance;
  logic        in_take;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = item_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LOOP_ENABLE: cfg_r.loop_enable <= cfg_wdata[0];
        CFG_ANGLE_A:     cfg_r.angle_a     <= cfg_wdata;
        CFG_ANGLE_B:     cfg_r.angle_b     <= cfg_wdata;
        CFG_DWELL_MS:    cfg_r.dwell_ms    <= cfg_wdata;
        CFG_LOOP_SPEED:  cfg_r.loop_speed  <= cfg_wdata;
        CFG_LOOP_TIME:   cfg_r.loop_time   <= cfg_wdata;
        CFG_GOAL_SPEED:  cfg_r.goal_speed  <= cfg_wdata;
        CFG_GOAL_TIME:   cfg_r.goal_time   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  sps_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (!item_valid_r || advance) begin
      item_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= '{mode: in_mode, now_ms: in_now_ms,
                  position_valid: in_position_valid, present_steps: in_present_steps};
    end
  end

  // loop state commits when the transaction moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_IDLE, toward_b: 1'b0, target_angle: '0,
                dwell_start: '0, last_angle: '0};
    end else if (item_valid_r && advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid_r && advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_move_valid    = res_r.move_valid;
  assign out_move_steps    = res_r.move_steps;
  assign out_move_speed    = res_r.move_speed;
  assign out_move_time     = res_r.move_time;
  assign out_present_angle = res_r.present_angle;
  assign out_loop_phase    = res_r.loop_phase;

endmodule

// ----- design/sps_checker.sv -----
// port-level checks of the servo ping-pong sequencer, bound to the top level
// depends on sps_pkg and servo_ping_pong_sequencer
`timescale 1ns / 1ps

module sps_checker import sps_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_move_valid,
  input logic [StepsW-1:0]    out_move_steps,
  input logic [15:0]          out_move_speed,
  input logic [15:0]          out_move_time,
  input logic [AngleW-1:0]    out_present_angle,
  input logic [1:0]           out_loop_phase
);

  // a move command always leaves the loop moving
  a_move_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_valid |-> out_loop_phase == PH_MOVING)
    else $error("move issued outside moving phase");

  // no command means zeroed command fields
  a_idle_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_move_valid |->
      out_move_steps == '0 && out_move_speed == '0 && out_move_time == '0)
    else $error("command fields set without move");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_move_steps <= MaxSteps && out_present_angle <= MaxAngle
                  && out_loop_phase != 2'd3)
    else $error("result field out of range");

  // a stalled result keeps its step count, angle and phase
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_move_steps)
                               && $stable(out_present_angle) && $stable(out_loop_phase))
    else $error("stalled result changed");

  // the input is only held back by a stalled result
  a_in_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> out_valid && out_stall)
    else $error("input stalled without result backpressure");

endmodule

bind servo_ping_pong_sequencer sps_checker u_sps_checker (.*);

// ----- verif/servo_ping_pong_sequencer_tb.sv -----
// self-checking testbench of the servo ping-pong sequencer: directed and random transactions
// depends on sps_pkg and servo_ping_pong_sequencer
`timescale 1ns / 1ps

module servo_ping_pong_sequencer_tb;
  import sps_pkg::*;

  localparam logic MODE_POLL  = 1'b0;
  localparam logic MODE_PARAM = 1'b1;
  localparam int   HoldCycles = 80;
  localparam int   PhaseCount = 10;
  localparam int   PhaseItems = 85;

  // mirrors the loop state and registers, queues the expected result of every transaction
  class servo_loop_scoreboard;
    sps_cfg_t    regs;
    phase_t      ph;
    bit          toward_b;
    logic [8:0]  target_deg;
    logic [31:0] dwell_t0;
    logic [8:0]  last_deg;
    sps_result_t pending_moves[$];
    int          errors, items_noted, results_checked, moves_issued, dwells_entered;

    function new();
      regs = '0;
      ph = PH_IDLE;
      toward_b = 1'b0;
      target_deg = '0;
      dwell_t0 = '0;
      last_deg = '0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [15:0] v);
      case (idx)
        CFG_LOOP_ENABLE: regs.loop_enable = v[0];
        CFG_ANGLE_A:     regs.angle_a = v;
        CFG_ANGLE_B:     regs.angle_b = v;
        CFG_DWELL_MS:    regs.dwell_ms = v;
        CFG_LOOP_SPEED:  regs.loop_speed = v;
        CFG_LOOP_TIME:   regs.loop_time = v;
        CFG_GOAL_SPEED:  regs.goal_speed = v;
        CFG_GOAL_TIME:   regs.goal_time = v;
        default: ;
      endcase
    endfunction

    function logic [8:0] reading_angle(logic [15:0] s);
      int a;
      a = (int'(s) * 270 + 512) >> 10;
      if (a > int'(MaxAngle)) a = int'(MaxAngle);
      return 9'(a);
    endfunction

    function sps_result_t command_move(logic [15:0] raw);
      sps_result_t r;
      int deg, stp;
      logic [15:0] spd, tim;
      r = '0;
      deg = int'(raw);
      // values above the swap limit came in with their bytes reversed
      if (raw > SwapLimit) deg = int'({raw[7:0], raw[15:8]});
      if (deg > int'(MaxAngle)) deg = int'(MaxAngle);
      spd = (regs.loop_speed != 0) ? regs.loop_speed : regs.goal_speed;
      tim = (regs.loop_time != 0) ? regs.loop_time : regs.goal_time;
      if (spd == 0 && tim == 0) spd = DefaultSpeed;
      // rounded degrees to steps, 1024 steps over 270 degrees
      stp = (deg * 1024 + 135) / 270;
      if (stp > int'(MaxSteps)) stp = int'(MaxSteps);
      target_deg = 9'(deg);
      r.move_valid = 1'b1;
      r.move_steps = 11'(stp);
      r.move_speed = spd;
      r.move_time = tim;
      moves_issued++;
      return r;
    endfunction

    function sps_result_t begin_loop();
      ph = PH_MOVING;
      toward_b = 1'b1;
      return command_move(regs.angle_a);
    endfunction

    function void note_item(sps_item_t it);
      sps_result_t r;
      int d;
      logic [31:0] elapsed, dwell;
      r = '0;
      items_noted++;
      if (it.mode == MODE_PARAM) begin
        if (regs.loop_enable) r = begin_loop();
        else ph = PH_IDLE;
      end else begin
        if (it.position_valid) last_deg = reading_angle(it.present_steps);
        if (regs.loop_enable) begin
          dwell = 32'((regs.dwell_ms != 0) ? regs.dwell_ms : DefaultDwell);
          case (ph)
            PH_IDLE: r = begin_loop();
            PH_MOVING: begin
              if (last_deg > target_deg) d = int'(last_deg - target_deg);
              else d = int'(target_deg - last_deg);
              if (d <= int'(ArriveTol)) begin
                ph = PH_DWELL;
                dwell_t0 = it.now_ms;
                dwells_entered++;
              end
            end
            PH_DWELL: begin
              elapsed = it.now_ms - dwell_t0;  // wraps with the millisecond counter
              if (elapsed >= dwell) begin
                ph = PH_MOVING;
                r = command_move(toward_b ? regs.angle_b : regs.angle_a);
                toward_b = !toward_b;
              end
            end
            default: ;
          endcase
        end else begin
          ph = PH_IDLE;
        end
      end
      r.present_angle = last_deg;
      r.loop_phase = ph;
      pending_moves.push_back(r);
    endfunction

    function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(sps_result_t got);
      sps_result_t want;
      if (pending_moves.size() == 0) begin
        $error("result transaction with nothing outstanding");
        errors++;
        return;
      end
      want = pending_moves.pop_front();
      results_checked++;
      cmp_field("move_valid", 16'(want.move_valid), 16'(got.move_valid));
      cmp_field("move_steps", 16'(want.move_steps), 16'(got.move_steps));
      cmp_field("move_speed", want.move_speed, got.move_speed);
      cmp_field("move_time", want.move_time, got.move_time);
      cmp_field("present_angle", 16'(want.present_angle), 16'(got.present_angle));
      cmp_field("loop_phase", 16'(want.loop_phase), 16'(got.loop_phase));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [CfgWidth-1:0]  cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_mode;
  logic [TimeW-1:0]     in_now_ms;
  logic                 in_position_valid;
  logic [RawStepsW-1:0] in_present_steps;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_move_valid;
  logic [StepsW-1:0]    out_move_steps;
  logic [15:0]          out_move_speed;
  logic [15:0]          out_move_time;
  logic [AngleW-1:0]    out_present_angle;
  logic [1:0]           out_loop_phase;

  servo_loop_scoreboard sb;
  bit          send_gaps;
  bit          recv_stalls;
  bit          hold_req;
  logic [31:0] wall_ms;
  int          config_sets;

  servo_ping_pong_sequencer uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_now_ms         (in_now_ms),
    .in_position_valid (in_position_valid),
    .in_present_steps  (in_present_steps),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_move_valid    (out_move_valid),
    .out_move_steps    (out_move_steps),
    .out_move_speed    (out_move_speed),
    .out_move_time     (out_move_time),
    .out_present_angle (out_present_angle),
    .out_loop_phase    (out_loop_phase)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("timeout with %0d transactions outstanding", sb.pending_moves.size());
    $display("servo_ping_pong_sequencer_tb NOT OK");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        out_stall <= 1'b0;
      end else if (recv_stalls && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(sps_result_t'({out_move_valid, out_move_steps, out_move_speed,
                                     out_move_time, out_present_angle, out_loop_phase}));
    end
  end

  task automatic send_item(input sps_item_t it);
    int gap;
    gap = 0;
    if (send_gaps && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_mode <= it.mode;
    in_now_ms <= it.now_ms;
    in_position_valid <= it.position_valid;
    in_present_steps <= it.present_steps;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
  endtask

  task automatic send_poll(input logic [31:0] now, input logic ok, input logic [15:0] stp);
    sps_item_t it;
    it.mode = MODE_POLL;
    it.now_ms = now;
    it.position_valid = ok;
    it.present_steps = stp;
    send_item(it);
  endtask

  task automatic send_param_write(input logic [31:0] now);
    sps_item_t it;
    it.mode = MODE_PARAM;
    it.now_ms = now;
    it.position_valid = 1'($urandom);
    it.present_steps = 16'($urandom);
    send_item(it);
  endtask

  // stop offering, wait for every outstanding result, let the pipeline drain
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_moves.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_idx_t idx, input logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic close_cfg();
    @(negedge clk);
    cfg_we <= 1'b0;
    config_sets++;
  endtask

  // raw steps whose reading lands on the given angle
  function automatic logic [15:0] steps_for(input int deg);
    if (deg < 0) deg = 0;
    return 16'((deg * 1024 + 135) / 270);
  endfunction

  function automatic logic [15:0] random_endpoint();
    logic [15:0] d;
    case ($urandom_range(0, 5))
      0: d = 16'd0;
      1: d = 16'($urandom_range(265, 280));
      2: d = 16'($urandom_range(0, 360));
      3: begin
        d = 16'($urandom_range(2, 270));
        d = {d[7:0], d[15:8]};
      end
      4: d = 16'($urandom_range(361, 65535));
      default: d = 16'hFFFF;
    endcase
    return d;
  endfunction

  task automatic random_config(input int p);
    logic [15:0] v;
    for (int i = 0; i < 8; i++) begin
      v = 16'($urandom);
      case (cfg_idx_t'(i))
        CFG_LOOP_ENABLE: v[0] = (p != 6);
        CFG_ANGLE_A, CFG_ANGLE_B: begin
          if (p > 1) v = random_endpoint();
        end
        CFG_DWELL_MS: begin
          if (p > 1) begin
            case ($urandom_range(0, 3))
              0: v = 16'd0;
              1: v = 16'($urandom_range(1, 100));
              2: v = 16'hFFFF;
              default: ;
            endcase
          end
        end
        default: begin
          if (p > 1 && $urandom_range(0, 1)) v = 16'd0;
        end
      endcase
      // first two settings sit at the extremes
      if (i != 0 && p == 0) v = 16'hFFFF;
      if (i != 0 && p == 1) v = 16'd0;
      set_reg(cfg_idx_t'(i), v);
    end
    close_cfg();
  endtask

  // mostly a servo that chases its target, with some noise mixed in
  task automatic random_item();
    sps_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0) wall_ms = $urandom;
    else if ($urandom_range(0, 9) == 0) wall_ms += $urandom_range(0, 70000);
    else wall_ms += $urandom_range(0, 80);
    it.mode = MODE_POLL;
    it.now_ms = wall_ms;
    it.position_valid = ($urandom_range(0, 9) != 0);
    it.present_steps = 16'($urandom_range(0, 1100));
    if (pick < 4) begin
      it.mode = 1'($urandom);
      it.now_ms = $urandom;
      it.position_valid = 1'($urandom);
      it.present_steps = 16'($urandom);
    end else if (pick < 9) begin
      it.mode = MODE_PARAM;
      it.present_steps = 16'($urandom);
    end else if (sb.ph == PH_MOVING && $urandom_range(0, 1)) begin
      it.present_steps = steps_for(int'(sb.target_deg) + int'($urandom_range(0, 10)) - 5);
    end
    send_item(it);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_LOOP_ENABLE;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_mode = MODE_POLL;
    in_now_ms = '0;
    in_position_valid = 1'b0;
    in_present_steps = '0;
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
    hold_req = 1'b0;
    wall_ms = '0;
    config_sets = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // loop disabled: readings, clamping, invalid reading, ignored parameter write
    send_poll(32'd0, 1'b1, 16'd0);
    send_poll(32'd20, 1'b1, 16'hFFFF);
    send_poll(32'd40, 1'b0, 16'd0);
    send_param_write(32'd60);
    send_poll(32'd80, 1'b1, 16'd512);
    settle();

    // swapped endpoint A, endpoint B above travel, default dwell and speed
    set_reg(CFG_LOOP_ENABLE, 16'd1);
    set_reg(CFG_ANGLE_A, 16'h5A00);
    set_reg(CFG_ANGLE_B, 16'd300);
    close_cfg();
    send_poll(32'd1000, 1'b1, 16'd0);
    send_poll(32'd1020, 1'b1, steps_for(60));
    send_poll(32'd1040, 1'b0, steps_for(90));
    send_poll(32'd1060, 1'b1, steps_for(87));
    send_poll(32'd1359, 1'b1, steps_for(87));
    send_poll(32'd1360, 1'b1, steps_for(87));
    send_poll(32'd1380, 1'b1, steps_for(270));
    send_poll(32'd1680, 1'b1, steps_for(270));
    send_param_write(32'd1700);
    settle();

    // time only, no speed; dwell across the millisecond wrap
    set_reg(CFG_ANGLE_A, 16'd361);
    set_reg(CFG_DWELL_MS, 16'd5);
    set_reg(CFG_LOOP_TIME, 16'd7);
    close_cfg();
    send_param_write(32'hFFFF_FFF0);
    send_poll(32'hFFFF_FFFE, 1'b1, 16'd1024);
    send_poll(32'd2, 1'b1, 16'd1024);
    send_poll(32'd3, 1'b1, 16'd1024);
    send_poll(32'd4, 1'b0, 16'd0);
    settle();

    // disable with the upper data bits set
    set_reg(CFG_LOOP_ENABLE, 16'hFFFE);
    close_cfg();
    send_poll(32'd30, 1'b1, 16'd700);
    send_param_write(32'd50);

    for (int p = 0; p < PhaseCount; p++) begin
      settle();
      random_config(p);
      send_gaps = (p < 8 && p != 5);
      recv_stalls = send_gaps;
      if (p == 2) wall_ms = 32'hFFFF_F000;
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 3 && i == 0) begin
          // back-to-back offers against a long result-side hold
          send_gaps = 1'b0;
          hold_req = 1'b1;
        end
        if (p == 3 && i == 40) send_gaps = 1'b1;
        random_item();
      end
    end
    settle();
    repeat (6) @(posedge clk);

    $display("%0d transactions over %0d register settings, %0d results checked",
             sb.items_noted, config_sets, sb.results_checked);
    $display("%0d moves commanded, %0d endpoint arrivals, %0d mismatches",
             sb.moves_issued, sb.dwells_entered, sb.errors);
    if (sb.errors == 0 && sb.pending_moves.size() == 0) begin
      $display("servo_ping_pong_sequencer_tb OK");
    end else begin
      $display("servo_ping_pong_sequencer_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- servo_ping_pong_sequencer.f -----
design/sps_pkg.sv
design/sps_step.sv
design/servo_ping_pong_sequencer.sv
design/sps_checker.sv
verif/servo_ping_pong_sequencer_tb.sv
